FILE: hw/rtl/pec_pkg.sv
// Package for the polynomial easing curve evaluator: widths, 16.16 constants,
// curve codes, pipeline control types and the fixed-point helper functions.
// No dependencies.
package pec_pkg;

  localparam int TIME_W     = 11;
  localparam int EASE_W     = 12;
  localparam int CURVE_W    = 5;
  localparam int FULL_SCALE = 1024;

  localparam int FRAC       = 16;
  localparam int ONE        = 65536;
  localparam int NORM_SHIFT = $clog2(ONE / FULL_SCALE);

  // operand and accumulator widths
  localparam int OW = 22;
  localparam int PW = 2 * OW;
  localparam int GW = 24;

  localparam int K_C1       = 111515;
  localparam int K_C2       = 170060;
  localparam int K_C3       = 177051;
  localparam int K_N1       = 495616;
  localparam int K_D1       = 180224;
  localparam int K_1P5      = 98304;
  localparam int K_0P75     = 49152;
  localparam int K_2P25     = 147456;
  localparam int K_0P9375   = 61440;
  localparam int K_2P5      = 163840;
  localparam int K_2P625    = 172032;
  localparam int K_0P984375 = 64512;
  localparam int K_C2P1     = K_C2 + ONE;
  localparam int K_C2P1X2   = 2 * K_C2P1;

  // bounce breakpoints and offsets, c / 2.75 in 16.16
  localparam int BNC_TH1  = int'((64'(ONE) * 64'(ONE)) / 64'(K_D1));
  localparam int BNC_TH2  = int'((64'(2 * ONE) * 64'(ONE)) / 64'(K_D1));
  localparam int BNC_TH3  = int'((64'(K_2P5) * 64'(ONE)) / 64'(K_D1));
  localparam int BNC_OFS1 = int'((64'(K_1P5) * 64'(ONE)) / 64'(K_D1));
  localparam int BNC_OFS2 = int'((64'(K_2P25) * 64'(ONE)) / 64'(K_D1));
  localparam int BNC_OFS3 = int'((64'(K_2P625) * 64'(ONE)) / 64'(K_D1));

  typedef logic signed [OW-1:0] opnd_t;
  typedef logic signed [GW-1:0] gval_t;

  localparam opnd_t ONE_O = OW'(ONE);
  localparam gval_t ONE_G = GW'(ONE);
  localparam gval_t TWO_G = GW'(2 * ONE);
  localparam gval_t FS_G  = GW'(FULL_SCALE);
  localparam gval_t SAT_HI = GW'(2 ** (EASE_W - 1) - 1);
  localparam gval_t SAT_LO = -(GW'(2 ** (EASE_W - 1)));

  typedef enum logic [CURVE_W-1:0] {
    CURVE_LINEAR,
    CURVE_QUAD_IN, CURVE_QUAD_OUT, CURVE_QUAD_INOUT,
    CURVE_CUBIC_IN, CURVE_CUBIC_OUT, CURVE_CUBIC_INOUT,
    CURVE_QUART_IN, CURVE_QUART_OUT, CURVE_QUART_INOUT,
    CURVE_QUINT_IN, CURVE_QUINT_OUT, CURVE_QUINT_INOUT,
    CURVE_BACK_IN, CURVE_BACK_OUT, CURVE_BACK_INOUT,
    CURVE_BOUNCE_IN, CURVE_BOUNCE_OUT, CURVE_BOUNCE_INOUT
  } curve_t;

  typedef enum logic [2:0] {AM_PASS, AM_X, AM_SELF, AM_KC3, AM_BADJ} a_mode_t;
  typedef enum logic [1:0] {BM_PASS, BM_X, BM_KC1} b_mode_t;

  typedef enum logic [3:0] {
    FIN_LIN, FIN_A, FIN_ONE_MINUS_A, FIN_ONE_MINUS_HALF_A, FIN_A_MINUS_B,
    FIN_ONE_PLUS_AB, FIN_HALF_A, FIN_HALF_A_2ONE, FIN_BOUNCE
  } fin_t;

  typedef enum logic [1:0] {BK_IN, BK_OUT, BK_INOUT_LO, BK_INOUT_HI} bnc_kind_t;

  typedef struct packed {
    a_mode_t   am2;
    a_mode_t   am3;
    a_mode_t   am4;
    b_mode_t   bm2;
    logic      badj_neg;
    fin_t      fin;
    bnc_kind_t bk;
    logic [1:0] bsel;
  } ctrl_t;

  // 16.16 product, truncated toward zero
  function automatic opnd_t fmul(opnd_t a, opnd_t b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] bias;
    logic signed [PW-1:0] q;
    p = a * b;
    bias = '0;
    if (p[PW-1]) bias = PW'(ONE - 1);
    q = (p + bias) >>> FRAC;
    return q[OW-1:0];
  endfunction

  // signed divide by 2**sh, truncated toward zero
  function automatic gval_t tdiv_pow2(gval_t v, int unsigned sh);
    gval_t bias;
    bias = '0;
    if (v[GW-1]) bias = (GW'(1) <<< sh) - GW'(1);
    return (v + bias) >>> sh;
  endfunction

  function automatic opnd_t a_step(a_mode_t m, opnd_t a, opnd_t b, opnd_t x,
                                   logic badj_neg);
    opnd_t kb;
    kb = badj_neg ? (b - OW'(K_C2)) : (b + OW'(K_C2));
    case (m)
      AM_PASS: return a;
      AM_X:    return fmul(a, x);
      AM_SELF: return fmul(a, a);
      AM_KC3:  return fmul(a, OW'(K_C3));
      AM_BADJ: return fmul(a, kb);
      default: return a;
    endcase
  endfunction

  function automatic opnd_t b_step(b_mode_t m, opnd_t b, opnd_t x);
    case (m)
      BM_PASS: return b;
      BM_X:    return fmul(b, x);
      BM_KC1:  return fmul(b, OW'(K_C1));
      default: return b;
    endcase
  endfunction

  function automatic gval_t bnc_add(logic [1:0] sel);
    case (sel)
      2'd0:    return '0;
      2'd1:    return GW'(K_0P75);
      2'd2:    return GW'(K_0P9375);
      default: return GW'(K_0P984375);
    endcase
  endfunction

endpackage

FILE: hw/rtl/pec_channel_ifs.sv
// Valid/ready channel interfaces of the easing curve evaluator.
// Depends on pec_pkg for payload widths.
interface pec_time_if;
  logic                          valid;
  logic                          ready;
  logic [pec_pkg::TIME_W-1:0]    time_pos;
  modport source (output valid, time_pos, input ready);
  modport sink   (input valid, time_pos, output ready);
endinterface

interface pec_ease_if;
  logic                          valid;
  logic                          ready;
  logic signed [pec_pkg::EASE_W-1:0] eased_pos;
  modport source (output valid, eased_pos, input ready);
  modport sink   (input valid, eased_pos, output ready);
endinterface

interface pec_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pec_pkg::CURVE_W-1:0]   curve_select;
  modport source (output valid, curve_select, input ready);
  modport sink   (input valid, curve_select, output ready);
endinterface

FILE: hw/rtl/polynomial_easing_curve_evaluator_unit.sv
// Top level of the polynomial easing curve evaluator: six-stage pipeline.
// Depends on pec_pkg and the channel interfaces in pec_channel_ifs.sv.
//
//  channel  dir  payload                 notes
//  sample   in   time_pos [10:0]         clamped to full scale
//  result   out  eased_pos [11:0] signed saturated
//  cfg      in   curve_select [4:0]      always ready
//
// One item per cycle while the result channel takes them; stages: operand prep,
// four multiply stages (two 22x22 lanes in the first two, one in the last two),
// then combine and output register.
// Reset clears the valid bits and the curve register to linear.
// Each stage holds while the one after it is full and stalled; bubbles close up.
module polynomial_easing_curve_evaluator_unit (
  input  logic          clk,
  input  logic          rst,
  pec_time_if.sink      sample,
  pec_ease_if.source    result,
  pec_cfg_if.sink       cfg
);

  typedef struct packed {
    pec_pkg::ctrl_t              ctrl;
    logic [pec_pkg::TIME_W-1:0]  t;
    pec_pkg::opnd_t              x;
    pec_pkg::opnd_t              a;
    pec_pkg::opnd_t              b;
  } stage_t;

  logic [pec_pkg::CURVE_W-1:0] curve_select;

  logic [4:0] v;
  logic       ov;
  logic [5:0] en;

  pec_pkg::ctrl_t              p_ctrl;
  logic [pec_pkg::TIME_W-1:0]  p_t;
  pec_pkg::opnd_t              p_x, p_a1, p_a2, p_b1, p_b2;
  stage_t                      st [1:4];
  logic signed [pec_pkg::EASE_W-1:0] eased;

  // prep signals
  pec_pkg::ctrl_t              c_next;
  logic [pec_pkg::TIME_W-1:0]  tc;
  logic                        low;
  logic [pec_pkg::TIME_W:0]    tb;
  pec_pkg::opnd_t f, m, r, d, fm1, fb, xb, x_next, a1_next, a2_next, b1_next, b2_next;
  logic [1:0]                  bsel;

  // final stage signals
  pec_pkg::gval_t ag, bg, g, scaled, yv;
  logic signed [pec_pkg::EASE_W-1:0] eased_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_select <= '0;
    end else if (cfg.valid) begin
      curve_select <= cfg.curve_select;
    end
  end

  always_comb begin
    en[5] = !ov || result.ready;
    for (int k = 4; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign sample.ready = en[0];

  // operand prep
  always_comb begin
    tc  = (sample.time_pos > pec_pkg::TIME_W'(pec_pkg::FULL_SCALE)) ?
          pec_pkg::TIME_W'(pec_pkg::FULL_SCALE) : sample.time_pos;
    low = tc < pec_pkg::TIME_W'(pec_pkg::FULL_SCALE / 2);
    f   = pec_pkg::OW'({tc, {pec_pkg::NORM_SHIFT{1'b0}}});
    m   = pec_pkg::ONE_O - f;
    r   = m <<< 1;
    fm1 = f - pec_pkg::ONE_O;
    d   = fm1 <<< 1;

    case (pec_pkg::curve_t'(curve_select))
      pec_pkg::CURVE_BOUNCE_IN:  tb = (pec_pkg::TIME_W + 1)'(pec_pkg::FULL_SCALE) - {1'b0, tc};
      pec_pkg::CURVE_BOUNCE_OUT: tb = {1'b0, tc};
      default: begin
        if (low) tb = (pec_pkg::TIME_W + 1)'(pec_pkg::FULL_SCALE) - {tc, 1'b0};
        else     tb = {tc, 1'b0} - (pec_pkg::TIME_W + 1)'(pec_pkg::FULL_SCALE);
      end
    endcase
    fb = pec_pkg::OW'({tb, {pec_pkg::NORM_SHIFT{1'b0}}});
    if (fb < pec_pkg::OW'(pec_pkg::BNC_TH1)) begin
      bsel = 2'd0;
      xb   = fb;
    end else if (fb < pec_pkg::OW'(pec_pkg::BNC_TH2)) begin
      bsel = 2'd1;
      xb   = fb - pec_pkg::OW'(pec_pkg::BNC_OFS1);
    end else if (fb < pec_pkg::OW'(pec_pkg::BNC_TH3)) begin
      bsel = 2'd2;
      xb   = fb - pec_pkg::OW'(pec_pkg::BNC_OFS2);
    end else begin
      bsel = 2'd3;
      xb   = fb - pec_pkg::OW'(pec_pkg::BNC_OFS3);
    end

    c_next.am2      = pec_pkg::AM_PASS;
    c_next.am3      = pec_pkg::AM_PASS;
    c_next.am4      = pec_pkg::AM_PASS;
    c_next.bm2      = pec_pkg::BM_PASS;
    c_next.badj_neg = 1'b0;
    c_next.fin      = pec_pkg::FIN_LIN;
    c_next.bk       = pec_pkg::BK_OUT;
    c_next.bsel     = bsel;
    x_next  = f;
    a1_next = f;
    a2_next = f;
    b1_next = '0;
    b2_next = '0;

    case (pec_pkg::curve_t'(curve_select))
      pec_pkg::CURVE_QUAD_IN: c_next.fin = pec_pkg::FIN_A;
      pec_pkg::CURVE_QUAD_OUT: begin
        a1_next = m;
        a2_next = m;
        c_next.fin = pec_pkg::FIN_ONE_MINUS_A;
      end
      pec_pkg::CURVE_QUAD_INOUT: begin
        if (low) begin
          a1_next = f <<< 1;
          c_next.fin = pec_pkg::FIN_A;
        end else begin
          a1_next = r;
          a2_next = r;
          c_next.fin = pec_pkg::FIN_ONE_MINUS_HALF_A;
        end
      end
      pec_pkg::CURVE_CUBIC_IN: begin
        c_next.am2 = pec_pkg::AM_X;
        c_next.fin = pec_pkg::FIN_A;
      end
      pec_pkg::CURVE_CUBIC_OUT: begin
        x_next = m;
        a1_next = m;
        a2_next = m;
        c_next.am2 = pec_pkg::AM_X;
        c_next.fin = pec_pkg::FIN_ONE_MINUS_A;
      end
      pec_pkg::CURVE_CUBIC_INOUT: begin
        c_next.am2 = pec_pkg::AM_X;
        if (low) begin
          a1_next = f <<< 2;
          c_next.fin = pec_pkg::FIN_A;
        end else begin
          x_next = r;
          a1_next = r;
          a2_next = r;
          c_next.fin = pec_pkg::FIN_ONE_MINUS_HALF_A;
        end
      end
      pec_pkg::CURVE_QUART_IN: begin
        c_next.am2 = pec_pkg::AM_X;
        c_next.am3 = pec_pkg::AM_X;
        c_next.fin = pec_pkg::FIN_A;
      end
      pec_pkg::CURVE_QUART_OUT: begin
        a1_next = m;
        a2_next = m;
        c_next.am2 = pec_pkg::AM_SELF;
        c_next.fin = pec_pkg::FIN_ONE_MINUS_A;
      end
      pec_pkg::CURVE_QUART_INOUT: begin
        if (low) begin
          a1_next = f <<< 3;
          c_next.am2 = pec_pkg::AM_X;
          c_next.am3 = pec_pkg::AM_X;
          c_next.fin = pec_pkg::FIN_A;
        end else begin
          a1_next = r;
          a2_next = r;
          c_next.am2 = pec_pkg::AM_SELF;
          c_next.fin = pec_pkg::FIN_ONE_MINUS_HALF_A;
        end
      end
      pec_pkg::CURVE_QUINT_IN: begin
        c_next.am2 = pec_pkg::AM_X;
        c_next.am3 = pec_pkg::AM_X;
        c_next.am4 = pec_pkg::AM_X;
        c_next.fin = pec_pkg::FIN_A;
      end
      pec_pkg::CURVE_QUINT_OUT: begin
        x_next = m;
        a1_next = m;
        a2_next = m;
        c_next.am2 = pec_pkg::AM_SELF;
        c_next.am3 = pec_pkg::AM_X;
        c_next.fin = pec_pkg::FIN_ONE_MINUS_A;
      end
      pec_pkg::CURVE_QUINT_INOUT: begin
        if (low) begin
          a1_next = f <<< 4;
          c_next.am2 = pec_pkg::AM_X;
          c_next.am3 = pec_pkg::AM_X;
          c_next.am4 = pec_pkg::AM_X;
          c_next.fin = pec_pkg::FIN_A;
        end else begin
          x_next = r;
          a1_next = r;
          a2_next = r;
          c_next.am2 = pec_pkg::AM_SELF;
          c_next.am3 = pec_pkg::AM_X;
          c_next.fin = pec_pkg::FIN_ONE_MINUS_HALF_A;
        end
      end
      pec_pkg::CURVE_BACK_IN: begin
        a1_next = pec_pkg::OW'(pec_pkg::K_C3);
        b1_next = pec_pkg::OW'(pec_pkg::K_C1);
        b2_next = f;
        c_next.am2 = pec_pkg::AM_X;
        c_next.am3 = pec_pkg::AM_X;
        c_next.bm2 = pec_pkg::BM_X;
        c_next.fin = pec_pkg::FIN_A_MINUS_B;
      end
      pec_pkg::CURVE_BACK_OUT: begin
        x_next = fm1;
        a1_next = fm1;
        a2_next = fm1;
        b1_next = fm1;
        b2_next = fm1;
        c_next.am2 = pec_pkg::AM_X;
        c_next.am3 = pec_pkg::AM_KC3;
        c_next.bm2 = pec_pkg::BM_KC1;
        c_next.fin = pec_pkg::FIN_ONE_PLUS_AB;
      end
      pec_pkg::CURVE_BACK_INOUT: begin
        c_next.am2 = pec_pkg::AM_BADJ;
        if (low) begin
          a1_next = f <<< 1;
          a2_next = f <<< 1;
          b1_next = pec_pkg::OW'(pec_pkg::K_C2P1X2);
          b2_next = f;
          c_next.badj_neg = 1'b1;
          c_next.fin = pec_pkg::FIN_HALF_A;
        end else begin
          a1_next = d;
          a2_next = d;
          b1_next = pec_pkg::OW'(pec_pkg::K_C2P1);
          b2_next = d;
          c_next.fin = pec_pkg::FIN_HALF_A_2ONE;
        end
      end
      pec_pkg::CURVE_BOUNCE_IN, pec_pkg::CURVE_BOUNCE_OUT,
      pec_pkg::CURVE_BOUNCE_INOUT: begin
        x_next = xb;
        a1_next = pec_pkg::OW'(pec_pkg::K_N1);
        a2_next = xb;
        c_next.am2 = pec_pkg::AM_X;
        c_next.fin = pec_pkg::FIN_BOUNCE;
        if (pec_pkg::curve_t'(curve_select) == pec_pkg::CURVE_BOUNCE_IN) begin
          c_next.bk = pec_pkg::BK_IN;
        end else if (pec_pkg::curve_t'(curve_select) == pec_pkg::CURVE_BOUNCE_OUT) begin
          c_next.bk = pec_pkg::BK_OUT;
        end else if (low) begin
          c_next.bk = pec_pkg::BK_INOUT_LO;
        end else begin
          c_next.bk = pec_pkg::BK_INOUT_HI;
        end
      end
      default: c_next.fin = pec_pkg::FIN_LIN;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      ov <= 1'b0;
    end else begin
      if (en[0]) v[0] <= sample.valid;
      for (int k = 1; k <= 4; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
      if (en[5]) ov <= v[4];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_ctrl <= c_next;
      p_t    <= tc;
      p_x    <= x_next;
      p_a1   <= a1_next;
      p_a2   <= a2_next;
      p_b1   <= b1_next;
      p_b2   <= b2_next;
    end
    if (en[1]) begin
      st[1].ctrl <= p_ctrl;
      st[1].t    <= p_t;
      st[1].x    <= p_x;
      st[1].a    <= pec_pkg::fmul(p_a1, p_a2);
      st[1].b    <= pec_pkg::fmul(p_b1, p_b2);
    end
    if (en[2]) begin
      st[2].ctrl <= st[1].ctrl;
      st[2].t    <= st[1].t;
      st[2].x    <= st[1].x;
      st[2].a    <= pec_pkg::a_step(st[1].ctrl.am2, st[1].a, st[1].b, st[1].x,
                                    st[1].ctrl.badj_neg);
      st[2].b    <= pec_pkg::b_step(st[1].ctrl.bm2, st[1].b, st[1].x);
    end
    if (en[3]) begin
      st[3].ctrl <= st[2].ctrl;
      st[3].t    <= st[2].t;
      st[3].x    <= st[2].x;
      st[3].a    <= pec_pkg::a_step(st[2].ctrl.am3, st[2].a, st[2].b, st[2].x,
                                    st[2].ctrl.badj_neg);
      st[3].b    <= st[2].b;
    end
    if (en[4]) begin
      st[4].ctrl <= st[3].ctrl;
      st[4].t    <= st[3].t;
      st[4].x    <= st[3].x;
      st[4].a    <= pec_pkg::a_step(st[3].ctrl.am4, st[3].a, st[3].b, st[3].x,
                                    st[3].ctrl.badj_neg);
      st[4].b    <= st[3].b;
    end
    if (en[5]) eased <= eased_next;
  end

  // combine, rescale, saturate
  always_comb begin
    ag = pec_pkg::GW'(st[4].a);
    bg = pec_pkg::GW'(st[4].b);
    case (st[4].ctrl.fin)
      pec_pkg::FIN_A:                g = ag;
      pec_pkg::FIN_ONE_MINUS_A:      g = pec_pkg::ONE_G - ag;
      pec_pkg::FIN_ONE_MINUS_HALF_A: g = pec_pkg::ONE_G - pec_pkg::tdiv_pow2(ag, 1);
      pec_pkg::FIN_A_MINUS_B:        g = ag - bg;
      pec_pkg::FIN_ONE_PLUS_AB:      g = pec_pkg::ONE_G + ag + bg;
      pec_pkg::FIN_HALF_A:           g = pec_pkg::tdiv_pow2(ag, 1);
      pec_pkg::FIN_HALF_A_2ONE:      g = pec_pkg::tdiv_pow2(ag + pec_pkg::TWO_G, 1);
      pec_pkg::FIN_BOUNCE:           g = ag + pec_pkg::bnc_add(st[4].ctrl.bsel);
      default:                       g = ag;
    endcase
    scaled = pec_pkg::tdiv_pow2(g, pec_pkg::NORM_SHIFT);

    yv = scaled;
    if (st[4].ctrl.fin == pec_pkg::FIN_LIN) begin
      yv = pec_pkg::GW'(st[4].t);
    end else if (st[4].ctrl.fin == pec_pkg::FIN_BOUNCE) begin
      case (st[4].ctrl.bk)
        pec_pkg::BK_IN:       yv = pec_pkg::FS_G - scaled;
        pec_pkg::BK_OUT:      yv = scaled;
        pec_pkg::BK_INOUT_LO: yv = pec_pkg::tdiv_pow2(pec_pkg::FS_G - scaled, 1);
        pec_pkg::BK_INOUT_HI: yv = pec_pkg::tdiv_pow2(pec_pkg::FS_G + scaled, 1);
        default:              yv = scaled;
      endcase
    end

    if (yv > pec_pkg::SAT_HI)      eased_next = pec_pkg::SAT_HI[pec_pkg::EASE_W-1:0];
    else if (yv < pec_pkg::SAT_LO) eased_next = pec_pkg::SAT_LO[pec_pkg::EASE_W-1:0];
    else                           eased_next = yv[pec_pkg::EASE_W-1:0];
  end

  assign result.valid     = ov;
  assign result.eased_pos = eased;

endmodule
